// File: src/midsu_pkg.sv
package midsu_pkg;

   // Field widths
   localparam int CHAN_W  = 8;
   localparam int TALLY_W = 23;
   localparam int SUM_W   = 40;
   localparam int MSE_W   = 24;
   localparam int PCT_W   = 15;

   // Divider sizes: dividend is the sum with 8 fraction bits appended
   localparam int DIV_NUM_W = SUM_W + 8;
   localparam int DIV_DEN_W = TALLY_W + 2;
   localparam int DIV_CNT_W = 6;

   localparam int TALLY_MAX  = (1 << TALLY_W) - 1;
   // 25600 = 100 * 256: the factor of 100, the 256 comes by a shift
   localparam int PCT_FACTOR = 100;
   localparam int PCT_MUL_W  = TALLY_W + 7;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      chan_type ref_red;
      chan_type ref_green;
      chan_type ref_blue;
      chan_type cmp_red;
      chan_type cmp_green;
      chan_type cmp_blue;
   } pixel_pair_type;

endpackage

// File: src/midsu_channels.sv
// Request channel: one reference/compared pixel pair
interface midsu_req_if;
   import midsu_pkg::*;

   logic     valid;
   logic     ready;
   chan_type ref_red;
   chan_type ref_green;
   chan_type ref_blue;
   chan_type cmp_red;
   chan_type cmp_green;
   chan_type cmp_blue;
   logic     last_pixel;

   modport source (output valid, ref_red, ref_green, ref_blue,
                   cmp_red, cmp_green, cmp_blue, last_pixel, input ready);
   modport sink   (input valid, ref_red, ref_green, ref_blue,
                   cmp_red, cmp_green, cmp_blue, last_pixel, output ready);
endinterface

// Response channel: per-image statistics
interface midsu_rsp_if;
   import midsu_pkg::*;

   logic               valid;
   logic               ready;
   logic [MSE_W-1:0]   mse_fixed;
   logic [PCT_W-1:0]   diff_percent_fixed;
   logic [TALLY_W-1:0] counted_pixels;
   logic [TALLY_W-1:0] differing_pixels;

   modport source (output valid, mse_fixed, diff_percent_fixed,
                   counted_pixels, differing_pixels, input ready);
   modport sink   (input valid, mse_fixed, diff_percent_fixed,
                   counted_pixels, differing_pixels, output ready);
endinterface

// File: src/masked_image_diff_stats_unit.sv
// Masked image difference statistics. Each request carries a reference and a
// compared RGB pixel; pairs with a pure white reference are skipped, others
// are counted, flagged as differing if any channel differs, and their squared
// channel differences summed. A request marked last_pixel yields one response
// (MSE and percentage of differing pixels, both with 8 fraction bits, floored
// and saturated; zero when nothing was counted) and clears the accumulators.
// Timing: one 8x8 squarer is shared over the three channels, so a counted pixel is
// squared in S_SQR before the next request is taken; a skipped one is not.
// On the last pixel, if any was counted, one restoring divider runs two
// 48-step divisions (MSE, then the percentage) before the response is ready.
// The block takes no request from acceptance until it returns to idle,
// including while a previous response is still waiting to be taken.
// The pixel count saturates at the smaller of MAX_PIXELS and 2^23-1; pixels
// arriving beyond it are ignored.
module masked_image_diff_stats_unit #(
   parameter int MAX_PIXELS = 4194304
) (
   input logic        clock,
   input logic        reset,
   midsu_req_if.sink   req_chan,
   midsu_rsp_if.source rsp_chan
);
   import midsu_pkg::*;

   localparam logic [TALLY_W-1:0] TALLY_LIMIT =
      TALLY_W'((MAX_PIXELS > TALLY_MAX) ? TALLY_MAX : MAX_PIXELS);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQR  = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_MSE  = 3'd3;
   localparam logic [2:0] S_PCT  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic [1:0] STEP_LAST = 2'd3;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   logic [2:0]           state_ff, state_in;
   pixel_pair_type       pix_ff, pix_in;
   logic                 last_ff, last_in;
   logic [1:0]           step_ff, step_in;
   logic [2*CHAN_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic [TALLY_W-1:0]   miss_ff, miss_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MSE_W-1:0]     mse_ff, mse_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MSE_W-1:0]     rsp_mse_ff, rsp_mse_in;
   logic [PCT_W-1:0]     rsp_pct_ff, rsp_pct_in;
   logic [TALLY_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [TALLY_W-1:0]   rsp_diff_ff, rsp_diff_in;

   logic                 accept;
   logic                 white;
   logic                 take;
   logic                 differs;
   chan_type             sel_a, sel_b, abs_d;
   logic [SUM_W:0]       acc_sum;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W:0]   rem_sub;
   logic                 qbit;
   logic [PCT_MUL_W-1:0] miss_x100;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && (state_ff == S_IDLE);

   assign white = (req_chan.ref_red == '1) && (req_chan.ref_green == '1) &&
                  (req_chan.ref_blue == '1);
   assign take  = !white && (tally_ff < TALLY_LIMIT);
   assign differs = (req_chan.ref_red != req_chan.cmp_red) ||
                    (req_chan.ref_green != req_chan.cmp_green) ||
                    (req_chan.ref_blue != req_chan.cmp_blue);

   // Channel select and absolute difference for the shared squarer
   always_comb begin
      case (step_ff)
         2'd0: begin
            sel_a = pix_ff.ref_red;
            sel_b = pix_ff.cmp_red;
         end
         2'd1: begin
            sel_a = pix_ff.ref_green;
            sel_b = pix_ff.cmp_green;
         end
         default: begin
            sel_a = pix_ff.ref_blue;
            sel_b = pix_ff.cmp_blue;
         end
      endcase
      abs_d = (sel_a >= sel_b) ? (sel_a - sel_b) : (sel_b - sel_a);
   end

   // Saturating accumulate of the registered square
   assign acc_sum = {1'b0, sum_ff} + (SUM_W+1)'(prod_ff);

   // One restoring divider step
   assign rem_shift = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign qbit      = (rem_shift >= {1'b0, den_ff});

   assign miss_x100 = PCT_MUL_W'(miss_ff) * PCT_MUL_W'(PCT_FACTOR);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      miss_in      = miss_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      mse_in       = mse_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_mse_in   = rsp_mse_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_diff_in  = rsp_diff_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pix_in.ref_red   = req_chan.ref_red;
               pix_in.ref_green = req_chan.ref_green;
               pix_in.ref_blue  = req_chan.ref_blue;
               pix_in.cmp_red   = req_chan.cmp_red;
               pix_in.cmp_green = req_chan.cmp_green;
               pix_in.cmp_blue  = req_chan.cmp_blue;
               last_in          = req_chan.last_pixel;
               step_in          = '0;
               if (take) begin
                  tally_in = tally_ff + 1'b1;
                  miss_in  = miss_ff + TALLY_W'(differs);
                  state_in = S_SQR;
               end else if (req_chan.last_pixel) begin
                  state_in = S_LOAD;
               end
            end
         end

         // Square channel 'step' while accumulating the previous square
         S_SQR: begin
            prod_in = abs_d * abs_d;
            if (step_ff != 2'd0) begin
               sum_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = last_ff ? S_LOAD : S_IDLE;
            end
         end

         // Set up the MSE division: (sum * 256) / (3 * count)
         S_LOAD: begin
            rem_in = '0;
            cnt_in = '0;
            if (tally_ff == '0) begin
               mse_in   = '0;
               num_in   = '0;
               state_in = S_OUT;
            end else begin
               num_in   = {sum_ff, 8'd0};
               den_in   = DIV_DEN_W'(tally_ff) + DIV_DEN_W'({tally_ff, 1'b0});
               state_in = S_MSE;
            end
         end

         S_MSE, S_PCT: begin
            rem_in = qbit ? rem_sub[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            num_in = {num_ff[DIV_NUM_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               if (state_ff == S_MSE) begin
                  // Saturate the MSE quotient, then start the percentage
                  mse_in   = (|num_in[DIV_NUM_W-1:MSE_W]) ? '1 : num_in[MSE_W-1:0];
                  num_in   = DIV_NUM_W'({miss_x100, 8'd0});
                  den_in   = DIV_DEN_W'(tally_ff);
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_PCT;
               end else begin
                  state_in = S_OUT;
               end
            end
         end

         // Hand over to the output register and clear the accumulators
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mse_in   = mse_ff;
               rsp_pct_in   = (|num_ff[DIV_NUM_W-1:PCT_W]) ? '1 : num_ff[PCT_W-1:0];
               rsp_cnt_in   = tally_ff;
               rsp_diff_in  = miss_ff;
               tally_in     = '0;
               miss_in      = '0;
               sum_in       = '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         tally_ff     <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      mse_ff      <= mse_in;
      rsp_mse_ff  <= rsp_mse_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_diff_ff <= rsp_diff_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.mse_fixed          = rsp_mse_ff;
   assign rsp_chan.diff_percent_fixed = rsp_pct_ff;
   assign rsp_chan.counted_pixels     = rsp_cnt_ff;
   assign rsp_chan.differing_pixels   = rsp_diff_ff;

endmodule

// File: dv/tb_masked_image_diff_stats_unit.sv
`timescale 1ns / 1ps

module tb_masked_image_diff_stats_unit;
   import midsu_pkg::*;

   // Pixel bound kept at the block's default
   localparam int TB_MAX_PIXELS = 4194304;
   localparam int PIXEL_BOUND   = (TB_MAX_PIXELS < TALLY_MAX) ? TB_MAX_PIXELS : TALLY_MAX;
   localparam logic [63:0] PCT_SCALE = 64'd25600;
   localparam logic [63:0] MSE_MAX   = (64'd1 << MSE_W) - 1;
   localparam logic [63:0] PCT_MAX   = (64'd1 << PCT_W) - 1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam chan_type WHITE_LEVEL = 8'hFF;
   localparam int RANDOM_PIXELS = 830;
   localparam int IDLE_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = 300;

   typedef struct packed {
      logic [MSE_W-1:0]   mse;
      logic [PCT_W-1:0]   pct;
      logic [TALLY_W-1:0] counted;
      logic [TALLY_W-1:0] differing;
   } image_stats_type;

   typedef struct {
      pixel_pair_type  pair;
      logic            is_last;
      logic            typed;
      image_stats_type stats;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   midsu_req_if req_bus ();
   midsu_rsp_if rsp_bus ();

   masked_image_diff_stats_unit #(
      .MAX_PIXELS(TB_MAX_PIXELS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state
   logic [TALLY_W-1:0] pixel_count;
   logic [TALLY_W-1:0] mismatch_count;
   logic [SUM_W-1:0]   square_total;

   image_stats_type pending_stats[$];
   stim_row_type    directed_rows[$];
   int              error_count = 0;
   int              idle_cycles = 0;

   function automatic logic [17:0] chan_sq_diff(input chan_type a, input chan_type b);
      logic [7:0] d;
      d = (a >= b) ? a - b : b - a;
      return 18'(d) * 18'(d);
   endfunction

   // Fold one accepted request into the image statistics; on the last pixel
   // produce the image result and clear the accumulators
   function automatic void accumulate_pixel(input pixel_pair_type p, input logic is_last,
                                            output logic emits, output image_stats_type st);
      logic             white;
      logic [17:0]      sq;
      logic [SUM_W:0]   wide_sum;
      logic [63:0]      mse_w;
      logic [63:0]      pct_w;
      white = (p.ref_red == WHITE_LEVEL) && (p.ref_green == WHITE_LEVEL)
              && (p.ref_blue == WHITE_LEVEL);
      if (!white && pixel_count < PIXEL_BOUND) begin
         sq = chan_sq_diff(p.ref_red, p.cmp_red) + chan_sq_diff(p.ref_green, p.cmp_green)
              + chan_sq_diff(p.ref_blue, p.cmp_blue);
         pixel_count = pixel_count + 1'b1;
         if (p.ref_red != p.cmp_red || p.ref_green != p.cmp_green
             || p.ref_blue != p.cmp_blue) begin
            mismatch_count = mismatch_count + 1'b1;
         end
         wide_sum = {1'b0, square_total} + (SUM_W + 1)'(sq);
         square_total = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
      end
      emits = is_last;
      st = '0;
      if (is_last) begin
         mse_w = '0;
         pct_w = '0;
         if (pixel_count != 0) begin
            mse_w = (64'(square_total) << 8) / (64'(pixel_count) * 64'd3);
            pct_w = (64'(mismatch_count) * PCT_SCALE) / 64'(pixel_count);
         end
         st.mse       = (mse_w > MSE_MAX) ? MSE_MAX[MSE_W-1:0] : mse_w[MSE_W-1:0];
         st.pct       = (pct_w > PCT_MAX) ? PCT_MAX[PCT_W-1:0] : pct_w[PCT_W-1:0];
         st.counted   = pixel_count;
         st.differing = mismatch_count;
         pixel_count    = '0;
         mismatch_count = '0;
         square_total   = '0;
      end
   endfunction

   task automatic add_row(input chan_type rr, rg, rb, cr, cg, cb, input logic is_last,
                          input logic typed, input int mse, pct, cnt, dif);
      stim_row_type row;
      row.pair    = '{rr, rg, rb, cr, cg, cb};
      row.is_last = is_last;
      row.typed   = typed;
      row.stats   = '{MSE_W'(mse), PCT_W'(pct), TALLY_W'(cnt), TALLY_W'(dif)};
      directed_rows.push_back(row);
   endtask

   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Present one request at the falling edge, hold it until accepted
   task automatic send_pixel(input pixel_pair_type pair, input logic is_last,
                             input logic typed, input image_stats_type typed_stats,
                             input int gap);
      logic            emits;
      image_stats_type want;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.ref_red    = pair.ref_red;
      req_bus.ref_green  = pair.ref_green;
      req_bus.ref_blue   = pair.ref_blue;
      req_bus.cmp_red    = pair.cmp_red;
      req_bus.cmp_green  = pair.cmp_green;
      req_bus.cmp_blue   = pair.cmp_blue;
      req_bus.last_pixel = is_last;
      req_bus.valid      = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      accumulate_pixel(pair, is_last, emits, want);
      if (emits) pending_stats.push_back(typed ? typed_stats : want);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Stimulus: directed table first, then random images
   initial begin : stimulus
      pixel_pair_type pair;
      image_stats_type no_stats;
      int  length;
      int  mode;
      int  sent;
      bit  calm;
      logic is_last;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.ref_red    = '0;
      req_bus.ref_green  = '0;
      req_bus.ref_blue   = '0;
      req_bus.cmp_red    = '0;
      req_bus.cmp_green  = '0;
      req_bus.cmp_blue   = '0;
      req_bus.last_pixel = 1'b0;
      pixel_count        = '0;
      mismatch_count     = '0;
      square_total       = '0;
      no_stats           = '0;
      sent               = 0;

      // image with nothing counted
      add_row(255, 255, 255,   0,   0,   0, 1, 1, 0, 0, 0, 0);
      // largest difference on a single pixel
      add_row(  0,   0,   0, 255, 255, 255, 1, 1, 16646400, 25600, 1, 1);
      // near-white reference is counted
      add_row(255, 255, 254, 255, 255, 254, 1, 1, 0, 0, 1, 0);
      add_row(255, 255, 255, 255, 255, 255, 1, 1, 0, 0, 0, 0);
      // mixed image with a skipped pixel in front
      add_row(255, 255, 255,   0,   0,   0, 0, 0, 0, 0, 0, 0);
      add_row(  0, 255, 255, 255, 255, 255, 0, 0, 0, 0, 0, 0);
      add_row(255,   0, 255, 255,   0, 255, 0, 0, 0, 0, 0, 0);
      add_row(255, 255,   0, 254, 254,   1, 1, 0, 0, 0, 0, 0);
      // identical pixels around a skipped one
      add_row(  0,   0,   0,   0,   0,   0, 0, 0, 0, 0, 0, 0);
      add_row(255, 255, 255,  12,  34,  56, 0, 0, 0, 0, 0, 0);
      add_row(  0,   0,   0,   0,   0,   0, 1, 1, 0, 0, 2, 0);
      add_row(  1,   2,   3,   4,   5,   6, 0, 0, 0, 0, 0, 0);
      add_row(200, 100,  50, 100, 200,  50, 0, 0, 0, 0, 0, 0);
      add_row(170,  85,  15,  85, 170, 240, 1, 0, 0, 0, 0, 0);
      add_row(128, 128, 128, 127, 129, 128, 1, 0, 0, 0, 0, 0);
      add_row(255, 255, 255,  77,  88,  99, 1, 1, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].pair, directed_rows[i].is_last, directed_rows[i].typed,
                    directed_rows[i].stats, pick_gap(1'b0));
      end

      // Random images of mixed length, a few long ones
      while (sent < RANDOM_PIXELS) begin
         mode = $urandom_range(0, 99);
         if (mode < 55) length = $urandom_range(1, 12);
         else if (mode < 85) length = $urandom_range(13, 36);
         else length = $urandom_range(38, 70);
         calm = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < length; k++) begin
            pair = pixel_pair_type'(48'({$urandom, $urandom}));
            mode = $urandom_range(0, 99);
            if (mode < 12) begin
               pair.ref_red   = WHITE_LEVEL;
               pair.ref_green = WHITE_LEVEL;
               pair.ref_blue  = WHITE_LEVEL;
               if ($urandom_range(0, 3) == 0) begin
                  pair.cmp_red   = WHITE_LEVEL;
                  pair.cmp_green = WHITE_LEVEL;
                  pair.cmp_blue  = WHITE_LEVEL;
               end
            end else if (mode < 35) begin
               pair.cmp_red   = pair.ref_red;
               pair.cmp_green = pair.ref_green;
               pair.cmp_blue  = pair.ref_blue;
            end else if (mode < 55) begin
               pair.cmp_red   = pair.ref_red + chan_type'($urandom_range(0, 6)) - 8'd3;
               pair.cmp_green = pair.ref_green + chan_type'($urandom_range(0, 6)) - 8'd3;
               pair.cmp_blue  = pair.ref_blue + chan_type'($urandom_range(0, 6)) - 8'd3;
            end else if (mode < 68) begin
               pair.ref_red   = {8{$urandom_range(0, 1) == 1}};
               pair.ref_green = {8{$urandom_range(0, 1) == 1}};
               pair.ref_blue  = {8{$urandom_range(0, 1) == 1}};
               pair.cmp_red   = {8{$urandom_range(0, 1) == 1}};
               pair.cmp_green = {8{$urandom_range(0, 1) == 1}};
               pair.cmp_blue  = {8{$urandom_range(0, 1) == 1}};
            end
            is_last = (k == length - 1);
            sent++;
            send_pixel(pair, is_last, 1'b0, no_stats, pick_gap(calm));
         end
      end
      req_bus.valid = 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Response back-pressure: bursts of ready, short and occasional long stalls
   initial begin : rsp_stall
      int hold;
      int stall;
      int roll;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         hold = (roll < 85) ? $urandom_range(1, 10) : $urandom_range(100, 400);
         rsp_bus.ready = 1'b1;
         repeat (hold) @(negedge clock);
         roll = $urandom_range(0, 99);
         if (roll < 50) stall = 0;
         else if (roll < 85) stall = $urandom_range(1, 4);
         else stall = $urandom_range(10, 150);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // Compare each accepted response with the oldest expected image result
   always @(posedge clock) begin : rsp_check
      image_stats_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_stats.size() == 0) begin
            $error("response with no image result pending");
            error_count++;
         end else begin
            want = pending_stats.pop_front();
            check_field("mse_fixed", 64'(want.mse), 64'(rsp_bus.mse_fixed));
            check_field("diff_percent_fixed", 64'(want.pct), 64'(rsp_bus.diff_percent_fixed));
            check_field("counted_pixels", 64'(want.counted), 64'(rsp_bus.counted_pixels));
            check_field("differing_pixels", 64'(want.differing),
                        64'(rsp_bus.differing_pixels));
         end
      end
   end

   // Watchdog: too long with no request or response accepted
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
          || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
